// ===== rtl/lwc_pkg.sv =====
// Shared types and constants for the line window clipper.
`default_nettype none
package lwc_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM  = 3'd4;

  // reset window in whole units
  localparam int X_MAX_UNITS = 800;
  localparam int Y_MAX_UNITS = 600;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic zero;  // zero direction
    logic vert;  // vertical line
  } kind_t;

  localparam int KIND_W = $bits(kind_t);

endpackage
`default_nettype wire

// ===== rtl/line_window_clip.sv =====
// Top level: configuration registers, front end, work queue and back end.
//
// Clips an infinite line to the configured window and scales both endpoints by zoom.
// One line is taken per clock (start while busy is low) and every line gives one word
// on the out_ ports, marked by out_valid for one cycle (Q16.16 with the default widths);
// the two chained pipelined dividers of each endpoint lane work one quotient bit per stage.
// Results leave in input order and the receiver cannot hold them off. Write the cfg_
// registers only while no line is in flight.
`default_nettype none
module line_window_clip #(
  parameter int WORD_BITS = lwc_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = lwc_pkg::DEF_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [WORD_BITS-1:0]          in_dir_x,
  input  wire logic [WORD_BITS-1:0]          in_dir_y,
  input  wire logic [WORD_BITS-1:0]          in_point_x,
  input  wire logic [WORD_BITS-1:0]          in_point_y,
  output logic                               out_valid,
  output logic [WORD_BITS-1:0]               out_start_x,
  output logic [WORD_BITS-1:0]               out_start_y,
  output logic [WORD_BITS-1:0]               out_end_x,
  output logic [WORD_BITS-1:0]               out_end_y,
  output logic                               out_failed,
  input  wire logic                          cfg_we,
  input  wire logic [lwc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [WORD_BITS-1:0]          cfg_wdata
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] X_MAX_RST = W'(lwc_pkg::X_MAX_UNITS) << FRAC_BITS;
  localparam logic [W-1:0] Y_MAX_RST = W'(lwc_pkg::Y_MAX_UNITS) << FRAC_BITS;
  localparam logic [W-1:0] ZOOM_RST  = W'(1) << FRAC_BITS;

  localparam int QD = lwc_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);
  localparam int QW = 4 * W + lwc_pkg::KIND_W;

  // configuration
  logic [W-1:0] x_min_r, x_max_r, y_min_r, y_max_r, zoom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      x_max_r <= X_MAX_RST;
      y_min_r <= '0;
      y_max_r <= Y_MAX_RST;
      zoom_r  <= ZOOM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lwc_pkg::REG_X_MIN: x_min_r <= cfg_wdata;
        lwc_pkg::REG_X_MAX: x_max_r <= cfg_wdata;
        lwc_pkg::REG_Y_MIN: y_min_r <= cfg_wdata;
        lwc_pkg::REG_Y_MAX: y_max_r <= cfg_wdata;
        lwc_pkg::REG_ZOOM:  zoom_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end
  logic           accept;
  logic           f_vld;
  logic [W-1:0]   f_a, f_b, f_c, f_px;
  lwc_pkg::kind_t f_kind;

  assign accept = start && !busy;

  lwc_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_dx    (in_dir_x),
    .in_dy    (in_dir_y),
    .in_px    (in_point_x),
    .in_py    (in_point_y),
    .out_vld  (f_vld),
    .out_a    (f_a),
    .out_b    (f_b),
    .out_c    (f_c),
    .out_px   (f_px),
    .out_kind (f_kind)
  );

  // work queue; the back end drains one word a cycle
  logic [QW-1:0] mem_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [QW-1:0] q_word;

  assign pop     = (cnt_r != '0);
  assign cnt_nxt = cnt_r + CW'(f_vld) - CW'(pop);
  // leave room for the two words still inside the front end
  assign busy    = (cnt_r >= CW'(QD - 2));
  assign q_word  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (f_vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
    if (f_vld) begin
      mem_r[wr_ptr_r] <= {f_a, f_b, f_c, f_px, f_kind};
    end
  end

  logic [W-1:0]   q_a, q_b, q_c, q_px;
  lwc_pkg::kind_t q_kind;

  assign {q_a, q_b, q_c, q_px, q_kind} = q_word;

  lwc_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (pop),
    .in_a        (q_a),
    .in_b        (q_b),
    .in_c        (q_c),
    .in_px       (q_px),
    .in_kind     (q_kind),
    .cfg_x_min   (x_min_r),
    .cfg_x_max   (x_max_r),
    .cfg_y_min   (y_min_r),
    .cfg_y_max   (y_max_r),
    .cfg_zoom    (zoom_r),
    .out_vld     (out_valid),
    .out_start_x (out_start_x),
    .out_start_y (out_start_y),
    .out_end_x   (out_end_x),
    .out_end_y   (out_end_y),
    .out_failed  (out_failed)
  );

endmodule
`default_nettype wire

// ===== rtl/lwc_mul.sv =====
// Registered saturating fixed-point multiplier with sideband.
`default_nettype none
module lwc_mul #(
  parameter int W        = lwc_pkg::DEF_WORD_BITS,
  parameter int F        = lwc_pkg::DEF_FRAC_BITS,
  parameter int SW       = 1,
  parameter bit B_SIGNED = 1'b1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  in_a,
  input  wire logic [W-1:0]  in_b,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [W-1:0]       out_res,
  output logic [SW-1:0]      out_side
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic           neg;
  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] prod, sh;
  logic           ovf;
  logic [W-1:0]   res_nxt, res_r;
  logic [SW-1:0]  side_r;
  logic           vld_r;

  always_comb begin
    ma      = in_a[W-1] ? W'(-in_a) : in_a;
    mb      = (B_SIGNED && in_b[W-1]) ? W'(-in_b) : in_b;
    neg     = in_a[W-1] ^ (B_SIGNED & in_b[W-1]);
    prod    = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
    sh      = prod >> F;
    ovf     = |sh[2*W-1:W-1];
    if (ovf) begin
      res_nxt = neg ? WMIN : WMAX;
    end else begin
      res_nxt = neg ? W'(-sh[W-1:0]) : sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    res_r  <= res_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_res  = res_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// ===== rtl/lwc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating result.
`default_nettype none
module lwc_div #(
  parameter int W  = lwc_pkg::DEF_WORD_BITS,
  parameter int F  = lwc_pkg::DEF_FRAC_BITS,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  in_num,
  input  wire logic [W-1:0]  in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [W-1:0]       out_res,
  output logic [SW-1:0]      out_side
);

  localparam int N = W + F;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // qd holds the dividend bits still to come on top and quotient bits below
  logic [N-1:0]  qd_r   [N];
  logic [W:0]    rem_r  [N];
  logic [W-1:0]  den_r  [N];
  logic          neg_r  [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  logic [W-1:0]  mnum, mden;

  assign mnum = in_num[W-1] ? W'(-in_num) : in_num;
  assign mden = in_den[W-1] ? W'(-in_den) : in_den;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N-1:0]  qd_in;
    logic [W:0]    rem_in;
    logic [W-1:0]  den_in;
    logic          neg_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [W:0]    shifted;
    logic          ge;
    logic [W:0]    rem_nxt;
    logic [N-1:0]  qd_nxt;

    if (i == 0) begin : g_first
      assign qd_in   = {mnum, {F{1'b0}}};
      assign rem_in  = '0;
      assign den_in  = mden;
      assign neg_in  = in_num[W-1] ^ in_den[W-1];
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign qd_in   = qd_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign neg_in  = neg_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    always_comb begin
      shifted = {rem_in[W-1:0], qd_in[N-1]};
      ge      = shifted >= {1'b0, den_in};
      rem_nxt = ge ? (shifted - {1'b0, den_in}) : shifted;
      qd_nxt  = {qd_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      qd_r[i]   <= qd_nxt;
      rem_r[i]  <= rem_nxt;
      den_r[i]  <= den_in;
      neg_r[i]  <= neg_in;
      side_r[i] <= side_in;
    end
  end

  logic [N-1:0]  q;
  logic          ovf;
  logic [W-1:0]  res_nxt, res_r;
  logic [SW-1:0] oside_r;
  logic          ovld_r;

  always_comb begin
    q   = qd_r[N-1];
    ovf = |q[N-1:W-1];
    if (ovf) begin
      res_nxt = neg_r[N-1] ? WMIN : WMAX;
    end else begin
      res_nxt = neg_r[N-1] ? W'(-q[W-1:0]) : q[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[N-1];
    end
    res_r   <= res_nxt;
    oside_r <= side_r[N-1];
  end

  assign out_vld  = ovld_r;
  assign out_res  = res_r;
  assign out_side = oside_r;

endmodule
`default_nettype wire

// ===== rtl/lwc_front.sv =====
// Front end: classifies a line and forms its implicit coefficients a, b, c.
`default_nettype none
module lwc_front #(
  parameter int W = lwc_pkg::DEF_WORD_BITS,
  parameter int F = lwc_pkg::DEF_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  in_dx,
  input  wire logic [W-1:0]  in_dy,
  input  wire logic [W-1:0]  in_px,
  input  wire logic [W-1:0]  in_py,
  output logic               out_vld,
  output logic [W-1:0]       out_a,
  output logic [W-1:0]       out_b,
  output logic [W-1:0]       out_c,
  output logic [W-1:0]       out_px,
  output lwc_pkg::kind_t     out_kind
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0] SMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] SMIN = {2'b11, {(W-1){1'b0}}};
  localparam int SW = 3 * W + lwc_pkg::KIND_W;

  // -(x + y) with the saturation of an add followed by a negate
  function automatic logic [W-1:0] negsum(input logic [W-1:0] x, input logic [W-1:0] y);
    logic signed [W:0] s;
    s = $signed({x[W-1], x}) + $signed({y[W-1], y});
    if (s > SMAX) begin
      negsum = WMIN + 1'b1;
    end else if (s <= SMIN) begin
      negsum = WMAX;
    end else begin
      negsum = W'(-s);
    end
  endfunction

  logic [W-1:0]   b;
  lwc_pkg::kind_t kind;

  always_comb begin
    b         = (in_dx == WMIN) ? WMAX : W'(-in_dx);
    kind.zero = (in_dx == '0) && (in_dy == '0);
    kind.vert = (in_dx == '0);
  end

  logic          m0_vld;
  logic [W-1:0]  p0, p1;
  logic [SW-1:0] m0_side;

  lwc_mul #(.W(W), .F(F), .SW(SW), .B_SIGNED(1'b1)) u_mul_apx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_a     (in_dy),
    .in_b     (in_px),
    .in_side  ({in_dy, b, in_px, kind}),
    .out_vld  (m0_vld),
    .out_res  (p0),
    .out_side (m0_side)
  );

  lwc_mul #(.W(W), .F(F), .SW(1), .B_SIGNED(1'b1)) u_mul_bpy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_a     (b),
    .in_b     (in_py),
    .in_side  (1'b0),
    .out_vld  (),
    .out_res  (p1),
    .out_side ()
  );

  logic           vld_r;
  logic [W-1:0]   a_r, b_r, c_r, px_r;
  lwc_pkg::kind_t kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= m0_vld;
    end
    c_r                       <= negsum(p0, p1);
    {a_r, b_r, px_r, kind_r}  <= m0_side;
  end

  assign out_vld  = vld_r;
  assign out_a    = a_r;
  assign out_b    = b_r;
  assign out_c    = c_r;
  assign out_px   = px_r;
  assign out_kind = kind_r;

endmodule
`default_nettype wire

// ===== rtl/lwc_lane.sv =====
// One endpoint: y at the border x, pulled back onto a y bound when outside.
`default_nettype none
module lwc_lane #(
  parameter int W = lwc_pkg::DEF_WORD_BITS,
  parameter int F = lwc_pkg::DEF_FRAC_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [W-1:0]   in_a,
  input  wire logic [W-1:0]   in_b,
  input  wire logic [W-1:0]   in_c,
  input  wire logic [W-1:0]   in_px,
  input  wire lwc_pkg::kind_t in_kind,
  input  wire logic [W-1:0]   cfg_bx,
  input  wire logic [W-1:0]   cfg_ylo,
  input  wire logic [W-1:0]   cfg_yhi,
  input  wire logic [W-1:0]   cfg_yv,
  output logic                out_vld,
  output logic [W-1:0]        out_x,
  output logic [W-1:0]        out_y,
  output logic                out_ok
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0] SMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] SMIN = {2'b11, {(W-1){1'b0}}};

  // sideband layout {a, b, c, px, kind}, then {y, inwin, by} on top
  localparam int KW     = lwc_pkg::KIND_W;
  localparam int OFF_PX = KW;
  localparam int OFF_C  = W + KW;
  localparam int OFF_B  = 2 * W + KW;
  localparam int OFF_A  = 3 * W + KW;
  localparam int SW1    = 4 * W + KW;
  localparam int OFF_BY = SW1;
  localparam int OFF_IN = SW1 + W;
  localparam int OFF_Y  = SW1 + W + 1;
  localparam int SW2    = SW1 + 2 * W + 1;

  function automatic logic [W-1:0] negsum(input logic [W-1:0] x, input logic [W-1:0] y);
    logic signed [W:0] s;
    s = $signed({x[W-1], x}) + $signed({y[W-1], y});
    if (s > SMAX) begin
      negsum = WMIN + 1'b1;
    end else if (s <= SMIN) begin
      negsum = WMAX;
    end else begin
      negsum = W'(-s);
    end
  endfunction

  // a * bx
  logic           m1_vld;
  logic [W-1:0]   p1;
  logic [SW1-1:0] m1_side;

  lwc_mul #(.W(W), .F(F), .SW(SW1), .B_SIGNED(1'b1)) u_mul_abx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_a     (in_a),
    .in_b     (cfg_bx),
    .in_side  ({in_a, in_b, in_c, in_px, in_kind}),
    .out_vld  (m1_vld),
    .out_res  (p1),
    .out_side (m1_side)
  );

  logic           v1_r;
  logic [W-1:0]   num1_r;
  logic [SW1-1:0] s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= m1_vld;
    end
    num1_r <= negsum(p1, m1_side[OFF_C +: W]);
    s1_r   <= m1_side;
  end

  // y at the border
  logic           d1_vld;
  logic [W-1:0]   y;
  logic [SW1-1:0] d1_side;

  lwc_div #(.W(W), .F(F), .SW(SW1)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_num   (num1_r),
    .in_den   (s1_r[OFF_B +: W]),
    .in_side  (s1_r),
    .out_vld  (d1_vld),
    .out_res  (y),
    .out_side (d1_side)
  );

  logic           v3_r, inwin_r;
  logic [W-1:0]   y_r, by_r;
  logic [SW1-1:0] s3_r;
  logic           below, above;

  always_comb begin
    below = $signed(y) < $signed(cfg_ylo);
    above = $signed(y) > $signed(cfg_yhi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= d1_vld;
    end
    y_r     <= y;
    inwin_r <= !below && !above;
    by_r    <= below ? cfg_ylo : cfg_yhi;
    s3_r    <= d1_side;
  end

  // b * by
  logic           m2_vld;
  logic [W-1:0]   p2;
  logic [SW2-1:0] m2_side;

  lwc_mul #(.W(W), .F(F), .SW(SW2), .B_SIGNED(1'b1)) u_mul_bby (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_a     (s3_r[OFF_B +: W]),
    .in_b     (by_r),
    .in_side  ({y_r, inwin_r, by_r, s3_r}),
    .out_vld  (m2_vld),
    .out_res  (p2),
    .out_side (m2_side)
  );

  logic           v5_r;
  logic [W-1:0]   num2_r;
  logic [SW2-1:0] s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= m2_vld;
    end
    num2_r <= negsum(p2, m2_side[OFF_C +: W]);
    s5_r   <= m2_side;
  end

  // x at the y bound; a of zero gives a result that is never used
  logic           d2_vld;
  logic [W-1:0]   x;
  logic [SW2-1:0] d2_side;

  lwc_div #(.W(W), .F(F), .SW(SW2)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_num   (num2_r),
    .in_den   (s5_r[OFF_A +: W]),
    .in_side  (s5_r),
    .out_vld  (d2_vld),
    .out_res  (x),
    .out_side (d2_side)
  );

  lwc_pkg::kind_t kind;
  logic [W-1:0]   x_nxt, y_nxt;
  logic           ok_nxt;

  always_comb begin
    kind = d2_side[KW-1:0];
    if (kind.zero) begin
      x_nxt  = '0;
      y_nxt  = '0;
      ok_nxt = 1'b0;
    end else if (kind.vert) begin
      x_nxt  = d2_side[OFF_PX +: W];
      y_nxt  = cfg_yv;
      ok_nxt = 1'b1;
    end else if (d2_side[OFF_IN]) begin
      x_nxt  = cfg_bx;
      y_nxt  = d2_side[OFF_Y +: W];
      ok_nxt = 1'b1;
    end else begin
      x_nxt  = x;
      y_nxt  = d2_side[OFF_BY +: W];
      ok_nxt = (d2_side[OFF_A +: W] != '0);
    end
  end

  logic         v7_r, ok_r;
  logic [W-1:0] x_r, y7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= d2_vld;
    end
    x_r  <= x_nxt;
    y7_r <= y_nxt;
    ok_r <= ok_nxt;
  end

  assign out_vld = v7_r;
  assign out_x   = x_r;
  assign out_y   = y7_r;
  assign out_ok  = ok_r;

endmodule
`default_nettype wire

// ===== rtl/lwc_back.sv =====
// Back end: both endpoint lanes, zoom scaling and the result register.
`default_nettype none
module lwc_back #(
  parameter int W = lwc_pkg::DEF_WORD_BITS,
  parameter int F = lwc_pkg::DEF_FRAC_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [W-1:0]   in_a,
  input  wire logic [W-1:0]   in_b,
  input  wire logic [W-1:0]   in_c,
  input  wire logic [W-1:0]   in_px,
  input  wire lwc_pkg::kind_t in_kind,
  input  wire logic [W-1:0]   cfg_x_min,
  input  wire logic [W-1:0]   cfg_x_max,
  input  wire logic [W-1:0]   cfg_y_min,
  input  wire logic [W-1:0]   cfg_y_max,
  input  wire logic [W-1:0]   cfg_zoom,
  output logic                out_vld,
  output logic [W-1:0]        out_start_x,
  output logic [W-1:0]        out_start_y,
  output logic [W-1:0]        out_end_x,
  output logic [W-1:0]        out_end_y,
  output logic                out_failed
);

  logic         l0_vld, ok0, ok1;
  logic [W-1:0] x0, y0, x1, y1;

  lwc_lane #(.W(W), .F(F)) u_lane_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_a    (in_a),
    .in_b    (in_b),
    .in_c    (in_c),
    .in_px   (in_px),
    .in_kind (in_kind),
    .cfg_bx  (cfg_x_min),
    .cfg_ylo (cfg_y_min),
    .cfg_yhi (cfg_y_max),
    .cfg_yv  (cfg_y_min),
    .out_vld (l0_vld),
    .out_x   (x0),
    .out_y   (y0),
    .out_ok  (ok0)
  );

  lwc_lane #(.W(W), .F(F)) u_lane_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_a    (in_a),
    .in_b    (in_b),
    .in_c    (in_c),
    .in_px   (in_px),
    .in_kind (in_kind),
    .cfg_bx  (cfg_x_max),
    .cfg_ylo (cfg_y_min),
    .cfg_yhi (cfg_y_max),
    .cfg_yv  (cfg_y_max),
    .out_vld (),
    .out_x   (x1),
    .out_y   (y1),
    .out_ok  (ok1)
  );

  logic         fail;
  logic         s_vld, s_fail;
  logic [W-1:0] sx0, sy0, sx1, sy1;

  assign fail = !ok0 || !ok1;

  lwc_mul #(.W(W), .F(F), .SW(1), .B_SIGNED(1'b0)) u_scale_x0 (
    .clk (clk), .rst_n (rst_n), .in_vld (l0_vld), .in_a (x0), .in_b (cfg_zoom),
    .in_side (fail), .out_vld (s_vld), .out_res (sx0), .out_side (s_fail)
  );

  lwc_mul #(.W(W), .F(F), .SW(1), .B_SIGNED(1'b0)) u_scale_y0 (
    .clk (clk), .rst_n (rst_n), .in_vld (l0_vld), .in_a (y0), .in_b (cfg_zoom),
    .in_side (1'b0), .out_vld (), .out_res (sy0), .out_side ()
  );

  lwc_mul #(.W(W), .F(F), .SW(1), .B_SIGNED(1'b0)) u_scale_x1 (
    .clk (clk), .rst_n (rst_n), .in_vld (l0_vld), .in_a (x1), .in_b (cfg_zoom),
    .in_side (1'b0), .out_vld (), .out_res (sx1), .out_side ()
  );

  lwc_mul #(.W(W), .F(F), .SW(1), .B_SIGNED(1'b0)) u_scale_y1 (
    .clk (clk), .rst_n (rst_n), .in_vld (l0_vld), .in_a (y1), .in_b (cfg_zoom),
    .in_side (1'b0), .out_vld (), .out_res (sy1), .out_side ()
  );

  logic         vld_r, failed_r;
  logic [W-1:0] sx0_r, sy0_r, sx1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s_vld;
    end
    failed_r <= s_fail;
    sx0_r    <= s_fail ? '0 : sx0;
    sy0_r    <= s_fail ? '0 : sy0;
    sx1_r    <= s_fail ? '0 : sx1;
    sy1_r    <= s_fail ? '0 : sy1;
  end

  assign out_vld     = vld_r;
  assign out_failed  = failed_r;
  assign out_start_x = sx0_r;
  assign out_start_y = sy0_r;
  assign out_end_x   = sx1_r;
  assign out_end_y   = sy1_r;

endmodule
`default_nettype wire
